@@ rtl/scta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scta_pkg
// Shared types, constants and keymaps of the scan code line editor.
// ----------------------------------------------------------------------------
package scta_pkg;

   localparam int LINE_SIZE  = 128;
   localparam int KEY_COUNT  = 64;
   localparam int TERM_COUNT = 3;

   // request opcodes
   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_BEGIN = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   typedef enum logic [1:0] {
      ACT_ECHO   = 2'd0,
      ACT_ERASE  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_SWITCH = 2'd3
   } action_type;

   // modifier bit positions
   localparam int MOD_SHIFT   = 0;
   localparam int MOD_SHIFT_R = 1;
   localparam int MOD_ALT     = 2;
   localparam int MOD_ALT_R   = 3;
   localparam int MOD_CTRL    = 4;
   localparam int MOD_CTRL_R  = 5;
   localparam int MOD_CAPS    = 6;

   // scan codes
   localparam logic [7:0] SC_PREFIX    = 8'hE0;
   localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT   = 7'h36;
   localparam logic [6:0] KEY_CTRL     = 7'h1D;
   localparam logic [6:0] KEY_ALT      = 7'h38;
   localparam logic [6:0] KEY_CAPS     = 7'h3A;
   localparam logic [6:0] KEY_F1       = 7'h3B;
   localparam logic [6:0] KEY_F2       = 7'h3C;
   localparam logic [6:0] KEY_F3       = 7'h3D;
   localparam logic [6:0] KEY_BACKSP   = 7'h0E;
   localparam logic [6:0] KEY_TAB      = 7'h0F;
   localparam logic [6:0] KEY_ENTER    = 7'h1C;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_L = 8'h6C;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic                           prefix_pending;
      logic [6:0]                     modifier_bits;
      logic [1:0]                     screen_terminal;
      logic [TERM_COUNT-1:0][7:0]     line_count;
      logic [TERM_COUNT-1:0]          capture_on;
   } state_type;

   typedef struct packed {
      action_type action;
      logic [7:0] character;
      logic       stored;
      logic [6:0] position;
   } result_type;

   function automatic logic [7:0] plain_map(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'h02: ch = "1";    7'h03: ch = "2";    7'h04: ch = "3";    7'h05: ch = "4";
         7'h06: ch = "5";    7'h07: ch = "6";    7'h08: ch = "7";    7'h09: ch = "8";
         7'h0A: ch = "9";    7'h0B: ch = "0";    7'h0C: ch = "-";    7'h0D: ch = "=";
         7'h10: ch = "q";    7'h11: ch = "w";    7'h12: ch = "e";    7'h13: ch = "r";
         7'h14: ch = "t";    7'h15: ch = "y";    7'h16: ch = "u";    7'h17: ch = "i";
         7'h18: ch = "o";    7'h19: ch = "p";    7'h1A: ch = "[";    7'h1B: ch = "]";
         7'h1E: ch = "a";    7'h1F: ch = "s";    7'h20: ch = "d";    7'h21: ch = "f";
         7'h22: ch = "g";    7'h23: ch = "h";    7'h24: ch = "j";    7'h25: ch = "k";
         7'h26: ch = "l";    7'h27: ch = ";";    7'h28: ch = 8'h27;  7'h29: ch = 8'h60;
         7'h2B: ch = 8'h5C;  7'h2C: ch = "z";    7'h2D: ch = "x";    7'h2E: ch = "c";
         7'h2F: ch = "v";    7'h30: ch = "b";    7'h31: ch = "n";    7'h32: ch = "m";
         7'h33: ch = ",";    7'h34: ch = ".";    7'h35: ch = "/";    7'h39: ch = CHAR_SPACE;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] shift_map(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'h02: ch = "!";    7'h03: ch = "@";    7'h04: ch = "#";    7'h05: ch = "$";
         7'h06: ch = "%";    7'h07: ch = "^";    7'h08: ch = "&";    7'h09: ch = "*";
         7'h0A: ch = "(";    7'h0B: ch = ")";    7'h0C: ch = "_";    7'h0D: ch = "+";
         7'h1A: ch = "{";    7'h1B: ch = "}";    7'h27: ch = ":";    7'h28: ch = 8'h22;
         7'h29: ch = "~";    7'h2B: ch = "|";    7'h33: ch = "<";    7'h34: ch = ">";
         7'h35: ch = "?";    7'h39: ch = CHAR_SPACE;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

@@ rtl/scancode_to_ascii_line_editor_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_editor_core
// Scan code set 1 keyboard decoder with per-terminal line capture.
// ----------------------------------------------------------------------------
// Request channel (req_*): one word per keyboard byte or begin/end line read.
// Response channel (rsp_*): zero to four words per request, the final one of
// a request marked by rsp_last. Both channels use valid/stall; a word moves
// on a clock edge with valid high and stall low.
// A request word is captured in an input register, decoded from there once
// no tab is being emitted and the output register is free, and its first
// response lands in the output register. A tab holds the decoder until
// its remaining spaces are emitted; every other request gives at most one
// response word.
// The output register drains while the next request is already accepted;
// when rsp_stall is high the output holds and, once the input register is
// occupied too, req_stall rises.
// Synchronous reset clears the modifiers, caps lock, prefix flag, shown
// terminal, line counters and capture flags, and empties both registers.
// ----------------------------------------------------------------------------
module scancode_to_ascii_line_editor_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_scan_code,
   input  wire logic [1:0] req_terminal,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_action,
   output logic [7:0]      rsp_character,
   output logic            rsp_stored,
   output logic [6:0]      rsp_position,
   output logic [1:0]      rsp_target_terminal,
   output logic            rsp_last
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           in_opcode_ff;
   logic [7:0]           in_scan_ff;
   logic [1:0]           in_term_ff;

   // editor state
   scta_pkg::state_type  state_ff, state_nxt;

   // tab space emitter
   logic [2:0]           tab_rem_ff, tab_rem_in;
   logic [6:0]           tab_pos_ff, tab_pos_in;
   logic                 tab_stored_ff, tab_stored_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   scta_pkg::result_type out_res_ff, out_res_in;
   logic [1:0]           out_term_ff, out_term_in;
   logic                 out_last_ff, out_last_in;

   scta_pkg::result_type dec_res;
   logic [2:0]           dec_count;

   logic                 out_free;
   logic                 busy;
   logic                 in_take;
   logic                 load_first;
   logic                 load_tab;

   scta_decode u_decode (
      .opcode    (in_opcode_ff),
      .scan_code (in_scan_ff),
      .terminal  (in_term_ff),
      .cur       (state_ff),
      .nxt       (state_nxt),
      .res       (dec_res),
      .res_count (dec_count)
   );

   always_comb begin
      out_free   = !out_valid_ff || !rsp_stall;
      busy       = (tab_rem_ff != 3'd0);
      in_take    = in_valid_ff && !busy && out_free;
      load_first = in_take && (dec_count != 3'd0);
      load_tab   = busy && out_free;
      req_stall  = in_valid_ff && !in_take;

      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end

      tab_rem_in    = tab_rem_ff;
      tab_pos_in    = tab_pos_ff;
      tab_stored_in = tab_stored_ff;
      out_res_in    = out_res_ff;
      out_term_in   = out_term_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      if (load_first) begin
         out_valid_in  = 1'b1;
         out_res_in    = dec_res;
         out_term_in   = state_nxt.screen_terminal;
         out_last_in   = (dec_count == 3'd1);
         // remaining tab spaces follow one per cycle while the output is not stalled
         tab_rem_in    = dec_count - 3'd1;
         tab_pos_in    = dec_res.position + 7'(dec_res.stored);
         tab_stored_in = dec_res.stored;
      end else if (load_tab) begin
         out_valid_in         = 1'b1;
         out_res_in.action    = scta_pkg::ACT_ECHO;
         out_res_in.character = scta_pkg::CHAR_SPACE;
         out_res_in.stored    = tab_stored_ff;
         out_res_in.position  = tab_pos_ff;
         out_term_in          = state_ff.screen_terminal;
         out_last_in          = (tab_rem_ff == 3'd1);
         tab_rem_in           = tab_rem_ff - 3'd1;
         tab_pos_in           = tab_pos_ff + 7'(tab_stored_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tab_rem_ff   <= 3'd0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         tab_rem_ff   <= tab_rem_in;
         if (in_take) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_opcode_ff <= req_opcode;
         in_scan_ff   <= req_scan_code;
         in_term_ff   <= req_terminal;
      end
      tab_pos_ff    <= tab_pos_in;
      tab_stored_ff <= tab_stored_in;
      out_res_ff    <= out_res_in;
      out_term_ff   <= out_term_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_action          = out_res_ff.action;
   assign rsp_character       = out_res_ff.character;
   assign rsp_stored          = out_res_ff.stored;
   assign rsp_position        = out_res_ff.position;
   assign rsp_target_terminal = out_term_ff;
   assign rsp_last            = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/scta_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scta_decode
// Decodes one request word against the editor state: next state, first
// result word and the number of result words it causes.
// ----------------------------------------------------------------------------
module scta_decode (
   input  wire logic [1:0]          opcode,
   input  wire logic [7:0]          scan_code,
   input  wire logic [1:0]          terminal,
   input  wire scta_pkg::state_type cur,
   output scta_pkg::state_type      nxt,
   output scta_pkg::result_type     res,
   output logic [2:0]               res_count
);

   logic [6:0] code;
   logic       rel;
   logic [7:0] cnt;
   logic       cap;
   logic [7:0] ch;
   logic       shift;
   logic       ctrl;
   logic       alt;
   logic       letter;
   logic [8:0] cnt_wide;
   logic [8:0] room;
   logic [2:0] spaces;
   logic [7:0] cnt_inc;

   always_comb begin
      code     = scan_code[6:0];
      rel      = scan_code[7];
      cnt      = cur.line_count[cur.screen_terminal];
      cap      = cur.capture_on[cur.screen_terminal];
      cnt_wide = {1'b0, cnt};
      room     = 9'(scta_pkg::LINE_SIZE - 1) - cnt_wide;
      spaces   = (!cap || room >= 9'd4) ? 3'd4 : room[2:0];
      // counter step for one echoed character while capture is on, saturating
      cnt_inc  = (cap && cnt != 8'hFF) ? cnt + 8'd1 : cnt;
      shift    = cur.modifier_bits[scta_pkg::MOD_SHIFT] | cur.modifier_bits[scta_pkg::MOD_SHIFT_R];
      ctrl     = cur.modifier_bits[scta_pkg::MOD_CTRL] | cur.modifier_bits[scta_pkg::MOD_CTRL_R];
      alt      = cur.modifier_bits[scta_pkg::MOD_ALT] | cur.modifier_bits[scta_pkg::MOD_ALT_R];
      ch       = scta_pkg::plain_map(code);
      letter   = (ch >= scta_pkg::CHAR_LOWER_A) && (ch <= scta_pkg::CHAR_LOWER_Z);

      nxt           = cur;
      res.action    = scta_pkg::ACT_ECHO;
      res.character = 8'h00;
      res.stored    = 1'b0;
      res.position  = 7'd0;
      res_count     = 3'd0;

      unique case (opcode)
         scta_pkg::OP_BEGIN, scta_pkg::OP_END: begin
            for (int i = 0; i < scta_pkg::TERM_COUNT; i++) begin
               if (terminal == 2'(i)) begin
                  nxt.line_count[i] = 8'd0;
                  nxt.capture_on[i] = (opcode == scta_pkg::OP_BEGIN);
               end
            end
         end
         scta_pkg::OP_SCAN: begin
            if (cur.prefix_pending) begin
               nxt.prefix_pending = 1'b0;
               if (code == scta_pkg::KEY_ALT) begin
                  nxt.modifier_bits[scta_pkg::MOD_ALT_R] = !rel;
               end else if (code == scta_pkg::KEY_CTRL) begin
                  nxt.modifier_bits[scta_pkg::MOD_CTRL_R] = !rel;
               end
            end else if (scan_code == scta_pkg::SC_PREFIX) begin
               nxt.prefix_pending = 1'b1;
            end else if (rel) begin
               if (code == scta_pkg::KEY_LSHIFT) begin
                  nxt.modifier_bits[scta_pkg::MOD_SHIFT] = 1'b0;
               end else if (code == scta_pkg::KEY_RSHIFT) begin
                  nxt.modifier_bits[scta_pkg::MOD_SHIFT_R] = 1'b0;
               end else if (code == scta_pkg::KEY_ALT) begin
                  nxt.modifier_bits[scta_pkg::MOD_ALT] = 1'b0;
               end else if (code == scta_pkg::KEY_CTRL) begin
                  nxt.modifier_bits[scta_pkg::MOD_CTRL] = 1'b0;
               end
            end else if ({1'b0, code} < 8'(scta_pkg::KEY_COUNT)) begin
               if (ch != 8'h00) begin
                  if (letter && ch == scta_pkg::CHAR_LOWER_L && ctrl) begin
                     res.action = scta_pkg::ACT_CLEAR;
                     res_count  = 3'd1;
                  end else begin
                     if (letter) begin
                        if (shift != cur.modifier_bits[scta_pkg::MOD_CAPS]) begin
                           ch = ch - scta_pkg::CASE_OFFSET;
                        end
                     end else if (shift) begin
                        ch = scta_pkg::shift_map(code);
                     end
                     if (cnt_wide + 9'd1 < 9'(scta_pkg::LINE_SIZE)) begin
                        res.character = ch;
                        res.stored    = cap;
                        res.position  = cap ? cnt[6:0] : 7'd0;
                        res_count     = 3'd1;
                        nxt.line_count[cur.screen_terminal] = cnt_inc;
                     end
                  end
               end else begin
                  case (code) inside
                     scta_pkg::KEY_ENTER: begin
                        if (cnt_wide < 9'(scta_pkg::LINE_SIZE)) begin
                           res.character = scta_pkg::CHAR_NEWLINE;
                           res.stored    = cap;
                           res.position  = cap ? cnt[6:0] : 7'd0;
                           res_count     = 3'd1;
                           nxt.line_count[cur.screen_terminal] = cnt_inc;
                        end
                     end
                     scta_pkg::KEY_TAB: begin
                        if (cnt_wide + 9'd1 < 9'(scta_pkg::LINE_SIZE)) begin
                           res.character = scta_pkg::CHAR_SPACE;
                           res.stored    = cap;
                           res.position  = cap ? cnt[6:0] : 7'd0;
                           res_count     = spaces;
                           if (cap) begin
                              nxt.line_count[cur.screen_terminal] = cnt + 8'(spaces);
                           end
                        end
                     end
                     scta_pkg::KEY_LSHIFT: nxt.modifier_bits[scta_pkg::MOD_SHIFT]   = 1'b1;
                     scta_pkg::KEY_RSHIFT: nxt.modifier_bits[scta_pkg::MOD_SHIFT_R] = 1'b1;
                     scta_pkg::KEY_ALT:    nxt.modifier_bits[scta_pkg::MOD_ALT]     = 1'b1;
                     scta_pkg::KEY_CTRL:   nxt.modifier_bits[scta_pkg::MOD_CTRL]    = 1'b1;
                     scta_pkg::KEY_CAPS: begin
                        nxt.modifier_bits[scta_pkg::MOD_CAPS] =
                           !cur.modifier_bits[scta_pkg::MOD_CAPS];
                     end
                     scta_pkg::KEY_F1, scta_pkg::KEY_F2, scta_pkg::KEY_F3: begin
                        if (alt) begin
                           nxt.screen_terminal = 2'(code - scta_pkg::KEY_F1);
                           res.action          = scta_pkg::ACT_SWITCH;
                           res_count           = 3'd1;
                        end
                     end
                     scta_pkg::KEY_BACKSP: begin
                        if (cap && cnt != 8'd0) begin
                           nxt.line_count[cur.screen_terminal] = cnt - 8'd1;
                           res.action   = scta_pkg::ACT_ERASE;
                           res.position = 7'(cnt - 8'd1);
                           res_count    = 3'd1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire
